### design/cpfm_pkg.sv
// shared types, constants and codes for the capture period frequency meter
`timescale 1ns / 1ps
package cpfm_pkg;

   localparam int COUNTER_BITS_DEFAULT  = 16;
   localparam int OVERFLOW_BITS_DEFAULT = 16;

   localparam int STAMP_BITS = 16;
   localparam int TICKS_BITS = 32;
   localparam int CLOCK_BITS = 27;
   localparam int OPCODE_BITS = 2;

   localparam logic [CLOCK_BITS-1:0] CLOCK_RESET = CLOCK_BITS'(8000000);

   localparam logic [OPCODE_BITS-1:0] OP_OVERFLOW = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_RISE     = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_FALL     = 2'd2;

   localparam logic RESULT_HIGH   = 1'b0;
   localparam logic RESULT_PERIOD = 1'b1;

   typedef enum logic [1:0] {
      PH_WAIT_RISE = 2'd0,
      PH_WAIT_FALL = 2'd1,
      PH_WAIT_END  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_DIVIDE = 2'd1,
      ST_LOAD   = 2'd2
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic div_step;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic has_result;
      logic need_div;
      logic div_done;
      logic out_free;
   } ctrl_status_type;

endpackage

### design/cpfm_if.sv
// valid/ready channel interfaces for event requests and measurement responses
`timescale 1ns / 1ps
interface cpfm_req_if import cpfm_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [OPCODE_BITS-1:0] opcode;
   logic [STAMP_BITS-1:0]  capture_value;

   modport source (output valid, output opcode, output capture_value, input ready);
   modport sink   (input valid, input opcode, input capture_value, output ready);
endinterface

interface cpfm_rsp_if import cpfm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  result_kind;
   logic [TICKS_BITS-1:0] elapsed_ticks;
   logic [CLOCK_BITS-1:0] frequency_hz;
   logic                  range_flag;

   modport source (output valid, output result_kind, output elapsed_ticks,
                   output frequency_hz, output range_flag, input ready);
   modport sink   (input valid, input result_kind, input elapsed_ticks,
                   input frequency_hz, input range_flag, output ready);
endinterface

### design/cpfm_ctrl.sv
// controller state machine: accept, divide and output load sequencing
`timescale 1ns / 1ps
module cpfm_ctrl import cpfm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.has_result) begin
               state_in = status.need_div ? ST_DIVIDE : ST_LOAD;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.accept   = 1'b0;
      cmd.div_step = 1'b0;
      cmd.out_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_LOAD: begin
            cmd.out_load = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

### design/cpfm_datapath.sv
// measurement state, span arithmetic, restoring divider and output register
`timescale 1ns / 1ps
module cpfm_datapath import cpfm_pkg::*; #(
   parameter int COUNTER_BITS  = COUNTER_BITS_DEFAULT,
   parameter int OVERFLOW_BITS = OVERFLOW_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CLOCK_BITS-1:0]  csr_wr_data,
   input  logic [OPCODE_BITS-1:0] req_opcode,
   input  logic [STAMP_BITS-1:0]  req_capture_value,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic                   rsp_result_kind,
   output logic [TICKS_BITS-1:0]  rsp_elapsed_ticks,
   output logic [CLOCK_BITS-1:0]  rsp_frequency_hz,
   output logic                   rsp_range_flag,
   input  ctrl_cmd_type           cmd,
   output ctrl_status_type        status
);

   localparam int SPAN_BITS = 64;
   localparam int CNT_BITS  = $clog2(CLOCK_BITS);
   localparam logic [STAMP_BITS-1:0] STAMP_MASK =
      STAMP_BITS'((64'd1 << COUNTER_BITS) - 64'd1);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(CLOCK_BITS - 1);

   logic [CLOCK_BITS-1:0]    clock_hz_ff;
   phase_type                phase_ff, phase_in;
   logic [STAMP_BITS-1:0]    start_ff, start_in;
   logic [OVERFLOW_BITS-1:0] ovf_ff, ovf_in;
   logic                     sat_ff, sat_in;

   logic                     kind_ff;
   logic [TICKS_BITS-1:0]    elapsed_ff;
   logic                     flag_ff;
   logic [TICKS_BITS-1:0]    rem_ff, rem_in;
   logic [CLOCK_BITS-1:0]    quo_ff, quo_in;
   logic [CNT_BITS-1:0]      cnt_ff;

   logic                     valid_ff;
   logic                     out_kind_ff;
   logic [TICKS_BITS-1:0]    out_elapsed_ff;
   logic [CLOCK_BITS-1:0]    out_freq_ff;
   logic                     out_flag_ff;

   logic [STAMP_BITS-1:0]    stamp;
   logic [SPAN_BITS-1:0]     span_wide;
   logic [TICKS_BITS-1:0]    span;
   logic                     is_period;
   logic                     is_high;
   logic [TICKS_BITS:0]      trial;
   logic                     trial_ge;

   assign stamp     = req_capture_value & STAMP_MASK;
   // overflow ticks weigh one full counter wrap each, kept modulo 2^32
   assign span_wide = SPAN_BITS'(stamp) + (SPAN_BITS'(ovf_ff) << COUNTER_BITS)
                      - SPAN_BITS'(start_ff);
   assign span      = span_wide[TICKS_BITS-1:0];
   assign is_period = (req_opcode == OP_RISE) && (phase_ff == PH_WAIT_END);
   assign is_high   = (req_opcode == OP_FALL) && (phase_ff == PH_WAIT_FALL);

   assign status.has_result = is_period || is_high;
   assign status.need_div   = is_period && (span != '0);
   assign status.div_done   = cnt_ff == CNT_LAST;
   assign status.out_free   = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= CLOCK_RESET;
      end else if (csr_wr_en) begin
         clock_hz_ff <= csr_wr_data;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      start_in = start_ff;
      ovf_in   = ovf_ff;
      sat_in   = sat_ff;
      case (req_opcode)
         OP_OVERFLOW: begin
            if (&ovf_ff) begin
               sat_in = 1'b1;
            end else begin
               ovf_in = ovf_ff + 1'b1;
            end
         end
         OP_RISE: begin
            // a rising edge opens a new pulse unless a falling edge is awaited
            if (phase_ff != PH_WAIT_FALL) begin
               start_in = stamp;
               ovf_in   = '0;
               sat_in   = 1'b0;
               phase_in = PH_WAIT_FALL;
            end
         end
         OP_FALL: begin
            if (phase_ff == PH_WAIT_FALL) begin
               phase_in = PH_WAIT_END;
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT_RISE;
         start_ff <= '0;
         ovf_ff   <= '0;
         sat_ff   <= 1'b0;
      end else if (cmd.accept) begin
         phase_ff <= phase_in;
         start_ff <= start_in;
         ovf_ff   <= ovf_in;
         sat_ff   <= sat_in;
      end
   end

   // restoring division, one quotient bit per cycle
   assign trial    = {rem_ff, quo_ff[CLOCK_BITS-1]};
   assign trial_ge = trial >= {1'b0, elapsed_ff};

   always_comb begin
      rem_in = trial_ge ? TICKS_BITS'(trial - {1'b0, elapsed_ff}) : trial[TICKS_BITS-1:0];
      quo_in = {quo_ff[CLOCK_BITS-2:0], trial_ge};
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff    <= is_period ? RESULT_PERIOD : RESULT_HIGH;
         elapsed_ff <= span;
         flag_ff    <= sat_ff || (is_period && (span == '0));
         rem_ff     <= '0;
         quo_ff     <= status.need_div ? clock_hz_ff : '0;
         cnt_ff     <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_kind_ff    <= kind_ff;
         out_elapsed_ff <= elapsed_ff;
         out_freq_ff    <= quo_ff;
         out_flag_ff    <= flag_ff;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_result_kind   = out_kind_ff;
   assign rsp_elapsed_ticks = out_elapsed_ff;
   assign rsp_frequency_hz  = out_freq_ff;
   assign rsp_range_flag    = out_flag_ff;

endmodule

### design/capture_period_frequency_meter_core.sv
// Capture period frequency meter: takes overflow, rising-edge and falling-edge
// events of a free-running capture counter and reports the high time at each
// falling edge and the period with clock_hz / period at each closing rising
// edge. Overflow ticks and edges that give no transaction leave the block ready
// for the next event; a high-time result or a zero period is loaded into the
// output register before the next event is accepted; a nonzero period first
// passes 27 steps of the restoring divider at one quotient bit per cycle. The
// load waits while the response side stalls; a waiting response does not hold
// up events that give no transaction. clock_hz is written through csr_wr_en;
// the user must do so only while idle; the block does not enforce it.
`timescale 1ns / 1ps
module capture_period_frequency_meter_core import cpfm_pkg::*; #(
   parameter int COUNTER_BITS  = COUNTER_BITS_DEFAULT,
   parameter int OVERFLOW_BITS = OVERFLOW_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CLOCK_BITS-1:0] csr_wr_data,
   cpfm_req_if.sink              req_bus,
   cpfm_rsp_if.source            rsp_bus
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   cpfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cpfm_datapath #(
      .COUNTER_BITS  (COUNTER_BITS),
      .OVERFLOW_BITS (OVERFLOW_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_opcode        (req_bus.opcode),
      .req_capture_value (req_bus.capture_value),
      .rsp_ready         (rsp_bus.ready),
      .rsp_valid         (rsp_bus.valid),
      .rsp_result_kind   (rsp_bus.result_kind),
      .rsp_elapsed_ticks (rsp_bus.elapsed_ticks),
      .rsp_frequency_hz  (rsp_bus.frequency_hz),
      .rsp_range_flag    (rsp_bus.range_flag),
      .cmd               (cmd),
      .status            (status)
   );

   // output register is only loaded when its previous transaction has gone
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_bus.valid || rsp_bus.ready))
      else $error("response overwritten before it was taken");

   // no event accepted while the divider is stepping
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> !req_bus.ready)
      else $error("event accepted during division");

   // high-time results carry no frequency
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.result_kind == RESULT_HIGH)) |-> (rsp_bus.frequency_hz == '0))
      else $error("high-time result with nonzero frequency");

   // a zero period must raise the range flag
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.result_kind == RESULT_PERIOD)
       && (rsp_bus.elapsed_ticks == '0)) |-> rsp_bus.range_flag)
      else $error("zero period without range flag");

endmodule

### verif/tb_capture_period_frequency_meter_core.sv
// self-checking testbench for the capture period frequency meter core
`timescale 1ns / 1ps
module tb_capture_period_frequency_meter_core;
   import cpfm_pkg::*;

   localparam logic [OPCODE_BITS-1:0] OP_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_STALL_CYCLES = 600;
   localparam int LONG_OVERFLOW_TICKS = 20;

   typedef struct {
      logic [OPCODE_BITS-1:0] opcode;
      logic [STAMP_BITS-1:0]  capture;
   } timer_event_type;

   typedef struct {
      logic                  kind;
      logic [TICKS_BITS-1:0] ticks;
      logic [CLOCK_BITS-1:0] freq;
      logic                  flag;
   } measurement_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CLOCK_BITS-1:0] csr_wr_data;

   cpfm_req_if req_ch ();
   cpfm_rsp_if rsp_ch ();

   capture_period_frequency_meter_core dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_ch),
      .rsp_bus     (rsp_ch)
   );

   timer_event_type pending_events[$];
   measurement_type expected_measurements[$];
   int              mismatch_count = 0;
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   bit              req_taken = 0;
   bit              long_stall_go = 0;

   // own copy of the meter state
   phase_type                meter_phase;
   logic [STAMP_BITS-1:0]    pulse_start;
   logic [15:0]              overflow_ticks;
   logic                     overflow_sat;
   logic [CLOCK_BITS-1:0]    model_clock_hz;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

   task automatic open_pulse(input logic [STAMP_BITS-1:0] stamp);
      pulse_start    = stamp;
      overflow_ticks = '0;
      overflow_sat   = 1'b0;
      meter_phase    = PH_WAIT_FALL;
   endtask

   task automatic predict_event(input logic [OPCODE_BITS-1:0] op,
                                input logic [STAMP_BITS-1:0] stamp);
      logic [63:0]     span;
      logic [31:0]     ticks;
      measurement_type m;
      span  = 64'(stamp) + (64'(overflow_ticks) << 16) - 64'(pulse_start);
      ticks = span[31:0];
      case (op)
         OP_OVERFLOW: begin
            if (overflow_ticks == '1) overflow_sat = 1'b1;
            else overflow_ticks = overflow_ticks + 1'b1;
         end
         OP_RISE: begin
            if (meter_phase == PH_WAIT_END) begin
               m.kind  = RESULT_PERIOD;
               m.ticks = ticks;
               m.flag  = overflow_sat || (ticks == 0);
               m.freq  = (ticks == 0) ? '0 : CLOCK_BITS'({5'b0, model_clock_hz} / ticks);
               expected_measurements.push_back(m);
               open_pulse(stamp);
            end else if (meter_phase != PH_WAIT_FALL) begin
               open_pulse(stamp);
            end
         end
         OP_FALL: begin
            if (meter_phase == PH_WAIT_FALL) begin
               m.kind  = RESULT_HIGH;
               m.ticks = ticks;
               m.freq  = '0;
               m.flag  = overflow_sat;
               expected_measurements.push_back(m);
               meter_phase = PH_WAIT_END;
            end
         end
         default: ;
      endcase
   endtask

   // prediction on every accepted transaction, register writes tracked too
   always @(posedge clock) begin
      req_taken = !reset && req_ch.valid && req_ch.ready;
      if (reset) begin
         meter_phase    = PH_WAIT_RISE;
         pulse_start    = '0;
         overflow_ticks = '0;
         overflow_sat   = 1'b0;
         model_clock_hz = CLOCK_RESET;
      end else if (csr_wr_en) begin
         model_clock_hz = csr_wr_data;
      end
      if (req_taken) begin
         predict_event(req_ch.opcode, req_ch.capture_value);
         void'(pending_events.pop_front());
      end
   end

   // sender: hold the offer until taken, idle at random between transactions
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_ch.valid         <= 1'b1;
            req_ch.opcode        <= pending_events[0].opcode;
            req_ch.capture_value <= pending_events[0].capture;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // receiver: random back-pressure plus an occasional long hold-off
   bit stall_seen = 0;
   int stall_left = 0;
   always @(negedge clock) begin
      if (long_stall_go != stall_seen) begin
         stall_seen = long_stall_go;
         stall_left = LONG_STALL_CYCLES;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      measurement_type m;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_measurements.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected transaction, expected none actual kind %0d ticks %0d",
                     $time, rsp_ch.result_kind, rsp_ch.elapsed_ticks);
         end else begin
            m = expected_measurements.pop_front();
            check_field("result_kind", 32'(m.kind), 32'(rsp_ch.result_kind));
            check_field("elapsed_ticks", m.ticks, rsp_ch.elapsed_ticks);
            check_field("frequency_hz", 32'(m.freq), 32'(rsp_ch.frequency_hz));
            check_field("range_flag", 32'(m.flag), 32'(rsp_ch.range_flag));
         end
      end
   end

   task automatic push_event(input logic [OPCODE_BITS-1:0] op,
                             input logic [STAMP_BITS-1:0] value);
      timer_event_type e;
      e.opcode  = op;
      e.capture = value;
      pending_events.push_back(e);
   endtask

   // mostly a well-formed pulse train with overflow ticks between edges, some noise
   task automatic queue_pulse_train(input int count);
      int                    pushed;
      int                    r;
      int                    n;
      bit                    next_rise;
      logic [STAMP_BITS-1:0] last_stamp;
      logic [STAMP_BITS-1:0] stamp;
      pushed     = 0;
      next_rise  = 1'b1;
      last_stamp = '0;
      while (pushed < count) begin
         r = $urandom_range(99);
         if (r < 12) begin
            push_event(OPCODE_BITS'($urandom_range(3)), STAMP_BITS'($urandom()));
            pushed++;
         end else if (r < 40) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(12, 4) : $urandom_range(3, 1);
            repeat (n) push_event(OP_OVERFLOW, STAMP_BITS'($urandom()));
            pushed += n;
         end else begin
            r = $urandom_range(9);
            if (r == 0) stamp = '0;
            else if (r == 1) stamp = '1;
            else if (r == 2) stamp = last_stamp;
            else stamp = STAMP_BITS'($urandom());
            push_event(next_rise ? OP_RISE : OP_FALL, stamp);
            next_rise  = !next_rise;
            last_stamp = stamp;
            pushed++;
         end
      end
   endtask

   task automatic write_clock_hz(input logic [CLOCK_BITS-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // block idle: nothing queued, nothing offered, nothing outstanding, divider settled
   task automatic wait_idle();
      while (pending_events.size() != 0 || req_ch.valid || expected_measurements.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [CLOCK_BITS-1:0] clk_hz, input int send_pct,
                            input int recv_pct, input int count, input bit hold_off);
      write_clock_hz(clk_hz);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      queue_pulse_train(count);
      if (hold_off) long_stall_go = !long_stall_go;
      wait_idle();
   endtask

   initial begin
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = '0;
      req_ch.valid         = 1'b0;
      req_ch.opcode        = OP_OVERFLOW;
      req_ch.capture_value = '0;
      rsp_ch.ready         = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part at the reset clock setting
      send_idle_pct = 23;
      recv_idle_pct = 59;
      push_event(OP_FALL, 16'd7);            // falling edge before any rising edge
      push_event(OP_RISE, 16'd100);
      push_event(OP_RISE, 16'd200);          // rising edge while waiting for falling
      push_event(OP_FALL, 16'hFFFF);
      push_event(OP_FALL, 16'd5);            // falling edge while waiting for period end
      push_event(OP_RISE, 16'd100);          // zero period
      push_event(OP_OVERFLOW, 16'hFFFF);
      push_event(OP_OVERFLOW, 16'd0);
      push_event(OP_FALL, 16'd0);
      push_event(OP_RISE, 16'hFFFF);
      push_event(OP_UNUSED, 16'hFFFF);
      push_event(OP_FALL, 16'hFFFF);
      push_event(OP_UNUSED, 16'd0);
      push_event(OP_RISE, 16'd0);            // wraps below the start stamp
      push_event(OP_FALL, 16'd1);
      push_event(OP_OVERFLOW, 16'd3);
      push_event(OP_RISE, 16'd1);
      push_event(OP_FALL, 16'h8000);
      push_event(OP_RISE, 16'h7FFF);
      wait_idle();

      run_phase(CLOCK_BITS'(1), 23, 59, 330, 1'b0);
      run_phase('1, 23, 59, 330, 1'b1);
      run_phase('0, 59, 23, 330, 1'b0);      // zero clock gives zero frequency
      run_phase(CLOCK_BITS'(100000000), 59, 23, 330, 1'b1);
      run_phase(CLOCK_BITS'($urandom_range(134217727, 1)), 0, 0, 330, 1'b0);

      // long run of overflow ticks inside one pulse, then a normal train at a low clock
      write_clock_hz(CLOCK_BITS'($urandom_range(1000, 1)));
      push_event(OP_RISE, 16'd1234);
      repeat (LONG_OVERFLOW_TICKS) push_event(OP_OVERFLOW, 16'd0);
      push_event(OP_FALL, 16'd4321);
      repeat (3) push_event(OP_OVERFLOW, 16'd0);
      push_event(OP_RISE, 16'd99);
      push_event(OP_FALL, 16'd100);
      queue_pulse_train(250);
      wait_idle();

      if (mismatch_count == 0 && expected_measurements.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
